// File: rtl/core/ssfb_pkg.sv
package ssfb_pkg;

	localparam logic [13:0] MAX_SHOWN    = 14'd9999;
	localparam logic [13:0] UNIT_THOU    = 14'd1000;
	localparam logic [13:0] UNIT_HUND    = 14'd100;
	localparam logic [13:0] UNIT_TEN     = 14'd10;
	localparam logic [3:0]  LAST_INDEX   = 4'd8;
	localparam logic [6:0]  ADDR_RESET   = 7'd112;
	localparam logic [7:0]  START_ADDR   = 8'h00;
	localparam logic [7:0]  PAD_BYTE     = 8'h00;
	localparam logic [7:0]  BLANK_BYTE   = 8'h00;

	localparam logic [7:0]  CFG_SHOW_ZEROS = 8'd0;
	localparam logic [7:0]  CFG_DEV_ADDR   = 8'd1;

	typedef struct packed {
		logic [6:0]      addr;
		logic [3:0][7:0] pat;
	} frame_entry_t;

	typedef struct packed {
		logic show_zeros;
		logic [6:0] dev_addr;
	} cfg_t;

	function automatic logic [3:0] digit_at(input logic [13:0] v, input logic [13:0] unit);
		logic [3:0] q;
		q = '0;
		for (int i = 1; i < 10; i++) begin
			if (v >= 14'(i) * unit) begin
				q = 4'(i);
			end
		end
		return q;
	endfunction

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] p;
		case (d)
			4'd0: p = 8'b00111111;
			4'd1: p = 8'b00000110;
			4'd2: p = 8'b01011011;
			4'd3: p = 8'b01001111;
			4'd4: p = 8'b01100110;
			4'd5: p = 8'b01101101;
			4'd6: p = 8'b01111101;
			4'd7: p = 8'b00000111;
			4'd8: p = 8'b01111111;
			4'd9: p = 8'b01101111;
			default: p = BLANK_BYTE;
		endcase
		return p;
	endfunction

endpackage

// File: rtl/core/ssfb_front.sv
module ssfb_front import ssfb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [15:0]  in_value,
	input  cfg_t         cfg,
	output logic         push,
	input  logic         full,
	output frame_entry_t push_entry
);

	logic        v1_s1;
	logic [3:0]  thou_s1;
	logic [9:0]  rem_s1;
	logic        v2_s2;
	logic [3:0]  thou_s2;
	logic [3:0]  hund_s2;
	logic [6:0]  rem_s2;

	logic        en2;
	logic [13:0] clamped;
	logic [3:0]  thou_d;
	logic [13:0] rem1_full;
	logic [3:0]  hund_d;
	logic [13:0] rem2_full;
	logic [3:0]  tens_d;
	logic [13:0] ones_full;
	logic [3:0]  ones_d;
	logic        blank0;
	logic        blank1;
	logic        blank2;

	assign push     = v2_s2 && !full;
	assign en2      = !v2_s2 || push;
	assign in_ready = !v1_s1 || en2;

	always_comb begin
		clamped   = (in_value > 16'(MAX_SHOWN)) ? MAX_SHOWN : in_value[13:0];
		thou_d    = digit_at(clamped, UNIT_THOU);
		rem1_full = clamped - 14'(thou_d) * UNIT_THOU;
		hund_d    = digit_at(14'(rem_s1), UNIT_HUND);
		rem2_full = 14'(rem_s1) - 14'(hund_d) * UNIT_HUND;
		tens_d    = digit_at(14'(rem_s2), UNIT_TEN);
		ones_full = 14'(rem_s2) - 14'(tens_d) * UNIT_TEN;
		ones_d    = ones_full[3:0];
	end

	always_comb begin
		blank0 = !cfg.show_zeros && (thou_s2 == 4'd0);
		blank1 = blank0 && (hund_s2 == 4'd0);
		blank2 = blank1 && (tens_d == 4'd0);
		push_entry.addr   = cfg.dev_addr;
		push_entry.pat[0] = blank0 ? BLANK_BYTE : seg_of(thou_s2);
		push_entry.pat[1] = blank1 ? BLANK_BYTE : seg_of(hund_s2);
		push_entry.pat[2] = blank2 ? BLANK_BYTE : seg_of(tens_d);
		push_entry.pat[3] = seg_of(ones_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v1_s1 <= in_valid;
			end
			if (en2) begin
				v2_s2 <= v1_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			thou_s1 <= thou_d;
			rem_s1  <= rem1_full[9:0];
		end
		if (en2) begin
			thou_s2 <= thou_s1;
			hund_s2 <= hund_d;
			rem_s2  <= rem2_full[6:0];
		end
	end

endmodule

// File: rtl/core/ssfb_queue.sv
module ssfb_queue import ssfb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  frame_entry_t push_entry,
	output logic         full,
	input  logic         pop,
	output logic         head_valid,
	output frame_entry_t head_entry
);

	frame_entry_t slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// File: rtl/core/ssfb_back.sv
module ssfb_back import ssfb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         head_valid,
	input  frame_entry_t head_entry,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   out_byte,
	output logic [3:0]   out_index,
	output logic         out_last,
	output logic [6:0]   out_addr
);

	logic       valid_q;
	logic [3:0] idx_q;
	logic [7:0] byte_q;
	logic [3:0] index_q;
	logic       last_q;
	logic [6:0] addr_q;

	logic       load;
	logic       at_last;
	logic [7:0] next_byte;

	assign load    = head_valid && (!valid_q || out_ready);
	assign at_last = (idx_q == LAST_INDEX);
	assign pop     = load && at_last;

	always_comb begin
		if (idx_q == 4'd0) begin
			next_byte = START_ADDR;
		end else if (idx_q[0]) begin
			next_byte = head_entry.pat[idx_q[2:1]];
		end else begin
			next_byte = PAD_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 4'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_last ? 4'd0 : idx_q + 4'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= next_byte;
			index_q <= idx_q;
			last_q  <= at_last;
			addr_q  <= head_entry.addr;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_index = index_q;
	assign out_last  = last_q;
	assign out_addr  = addr_q;

endmodule

// File: rtl/core/seven_segment_frame_builder.sv
// Each value taken on the slave stream is clamped to 9999, split into four decimal digits and
// turned into a nine-byte display RAM write frame on the master stream: start address 0x00,
// then each digit's gfedcba pattern followed by a 0x00 byte, with tlast on the ninth byte and
// the configured device address carried alongside every byte. Leading zero digits are blanked
// unless show_leading_zeros is set; the last digit always shows. In steady state the rate at
// which values are taken is set by the byte-wide output channel. A value passes through the
// digit-conversion registers and a two-entry queue before its frame's first byte is registered
// at the output; the queue lets the input keep flowing while the output stalls, until it fills.
module seven_segment_frame_builder import ssfb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] frame_byte, [11:8] byte_index, [18:12] target_address
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t         cfg_q;
	logic         push;
	logic         full;
	frame_entry_t push_entry;
	logic         pop;
	logic         head_valid;
	frame_entry_t head_entry;
	logic [7:0]   out_byte;
	logic [3:0]   out_index;
	logic [6:0]   out_addr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.show_zeros <= 1'b0;
			cfg_q.dev_addr   <= ADDR_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SHOW_ZEROS: cfg_q.show_zeros <= cfg_data[0];
				CFG_DEV_ADDR:   cfg_q.dev_addr   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	ssfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_value   (s_tdata),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.push_entry (push_entry)
	);

	ssfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	ssfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (out_byte),
		.out_index  (out_index),
		.out_last   (m_tlast),
		.out_addr   (out_addr)
	);

	assign m_tdata = {5'd0, out_addr, out_index, out_byte};

endmodule
